// ----- sv/assert_macros.svh -----
// Assertion macros shared by the record store RTL.
// Depends on nothing; the using module supplies clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SPRS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("record store assertion failed");
`define SPRS_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("record store assertion failed");
`else
`define SPRS_ASSERT_IMP(lbl, ante, cons)
`define SPRS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- sv/sprs_pkg.sv -----
// Package of the slotted page record store: beat types, codes, defaults.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package sprs_pkg;

   localparam int DEF_MAX_PAGES   = 16;
   localparam int DEF_MAX_SLOTS   = 64;
   localparam int DEF_RECORD_BITS = 64;

   localparam int ACTION_W    = 2;
   localparam int PAGE_IDX_W  = 4;
   localparam int SLOT_IDX_W  = 6;
   localparam int DATA_W      = 64;
   localparam int STATUS_W    = 2;
   localparam int CFG_W       = 7;

   localparam logic [CFG_W-1:0] SLOTS_RESET = 7'd64;

   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_UPDATE = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_READ   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DELETED  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0]   action;
      logic [PAGE_IDX_W-1:0] page_index;
      logic [SLOT_IDX_W-1:0] slot_index;
      logic [DATA_W-1:0]     record_data;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [PAGE_IDX_W-1:0] result_page;
      logic [SLOT_IDX_W-1:0] result_slot;
      logic [DATA_W-1:0]     read_data;
   } rsp_type;

   // Outcome of the free-slot search over one page.
   typedef struct packed {
      logic                  found;
      logic                  can_append;
      logic [SLOT_IDX_W-1:0] idx;
   } srch_type;

endpackage
`default_nettype wire

// ----- sv/sprs_slot_search.sv -----
// Free-slot search over one page: lowest dead slot below the count, append check.
// Depends on sprs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sprs_slot_search #(
   parameter int MAX_SLOTS = sprs_pkg::DEF_MAX_SLOTS,
   parameter int CNT_W     = $clog2(MAX_SLOTS + 1)
) (
   input  wire logic [MAX_SLOTS-1:0] alive,
   input  wire logic [CNT_W-1:0]     cnt,
   input  wire logic [CNT_W-1:0]     lim,
   output sprs_pkg::srch_type        srch
);

   logic [MAX_SLOTS-1:0] dead;

   always_comb begin
      for (int s = 0; s < MAX_SLOTS; s++) begin
         dead[s] = !alive[s] && (CNT_W'(s) < cnt);
      end
   end

   // Scan from the top so the lowest dead slot wins.
   always_comb begin
      srch.found      = 1'b0;
      srch.idx        = '0;
      srch.can_append = (cnt < lim);
      for (int s = MAX_SLOTS - 1; s >= 0; s--) begin
         if (dead[s]) begin
            srch.found = 1'b1;
            srch.idx   = sprs_pkg::SLOT_IDX_W'(s);
         end
      end
   end

endmodule
`default_nettype wire

// ----- sv/slotted_page_record_store.sv -----
// Slotted page record store: page metadata and record memories, sequencer.
// Depends on sprs_pkg, sprs_slot_search and assert_macros.svh.
// Sequence: accept, S_LOOK, S_EVAL, S_RDATA for read only, then S_FINISH into the rsp beat;
//   insert runs S_LOOK and S_EVAL per page checked, incl. the one past the last open page.
// Throughput: one item at a time; the next req beat is taken the cycle after
//   the result is loaded into the rsp register.
// Reset: synchronous, active high; one page open with no slots, all page rows
//   marked empty through per-page valid bits, slot limit back to 64.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module slotted_page_record_store #(
   parameter int MAX_PAGES   = sprs_pkg::DEF_MAX_PAGES,
   parameter int MAX_SLOTS   = sprs_pkg::DEF_MAX_SLOTS,
   parameter int RECORD_BITS = sprs_pkg::DEF_RECORD_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire sprs_pkg::req_type            req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output sprs_pkg::rsp_type                 rsp_data,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [sprs_pkg::CFG_W-1:0]   csr_data
);

   localparam int PCNT_W = $clog2(MAX_PAGES + 1);
   localparam int PAGE_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int META_W = CNT_W + MAX_SLOTS;
   localparam int REC_AW = PAGE_W + SLOT_W;
   localparam int CMP_W  = (PCNT_W > sprs_pkg::PAGE_IDX_W) ? PCNT_W : sprs_pkg::PAGE_IDX_W;
   localparam int SCMP_W = sprs_pkg::SLOT_IDX_W + 1;

   localparam logic [MAX_SLOTS-1:0] ONE_BIT = MAX_SLOTS'(1);

   // Sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOOK   = 3'd1;
   localparam logic [2:0] S_EVAL   = 3'd2;
   localparam logic [2:0] S_RDATA  = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0]                 state_ff, state_in;
   sprs_pkg::req_type          item_ff, item_in;
   logic                       page_oob_ff, page_oob_in;
   logic [PCNT_W-1:0]          page_ptr_ff, page_ptr_in;
   logic [PCNT_W-1:0]          pages_in_use_ff, pages_in_use_in;
   logic [sprs_pkg::CFG_W-1:0] slots_cfg_ff;
   sprs_pkg::rsp_type          res_ff, res_in;
   sprs_pkg::rsp_type          rsp_ff, rsp_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // Page metadata memory: {used count, alive marks} per page.
   logic [META_W-1:0]    meta_mem [MAX_PAGES];
   logic [META_W-1:0]    meta_q_ff;
   logic                 meta_vld_q_ff;
   logic [MAX_PAGES-1:0] page_vld_ff;
   logic                 meta_we;
   logic [META_W-1:0]    meta_wdata;
   logic [PAGE_W-1:0]    page_addr;

   // Record word memory, addressed by {page, slot}.
   logic [RECORD_BITS-1:0] rec_mem [MAX_PAGES << SLOT_W];
   logic [RECORD_BITS-1:0] rec_q_ff;
   logic                   rec_we;
   logic [SLOT_W-1:0]      rec_wslot;
   logic [REC_AW-1:0]      rec_waddr, rec_raddr;

   logic [CNT_W-1:0]           cur_cnt;
   logic [MAX_SLOTS-1:0]       cur_alive;
   logic [sprs_pkg::CFG_W-1:0] lim7;
   logic [CNT_W-1:0]           lim;
   logic                       slot_oob;
   logic                       rsp_free;
   sprs_pkg::srch_type         srch;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign page_addr = page_ptr_ff[PAGE_W-1:0];
   assign rec_waddr = {page_addr, rec_wslot};
   assign rec_raddr = {page_addr, item_ff.slot_index[SLOT_W-1:0]};

   // An unwritten page row reads as empty.
   assign cur_cnt   = meta_vld_q_ff ? meta_q_ff[META_W-1 -: CNT_W] : '0;
   assign cur_alive = meta_vld_q_ff ? meta_q_ff[MAX_SLOTS-1:0] : '0;
   assign slot_oob  = ({1'b0, item_ff.slot_index} >= SCMP_W'(cur_cnt));

   // Clamp the slot limit into 1..MAX_SLOTS.
   always_comb begin
      if (slots_cfg_ff == '0) begin
         lim7 = sprs_pkg::CFG_W'(1);
      end else if (slots_cfg_ff > sprs_pkg::CFG_W'(MAX_SLOTS)) begin
         lim7 = sprs_pkg::CFG_W'(MAX_SLOTS);
      end else begin
         lim7 = slots_cfg_ff;
      end
      lim = CNT_W'(lim7);
   end

   sprs_slot_search #(
      .MAX_SLOTS(MAX_SLOTS),
      .CNT_W    (CNT_W)
   ) u_search (
      .alive(cur_alive),
      .cnt  (cur_cnt),
      .lim  (lim),
      .srch (srch)
   );

   always_comb begin
      state_in        = state_ff;
      item_in         = item_ff;
      page_oob_in     = page_oob_ff;
      page_ptr_in     = page_ptr_ff;
      pages_in_use_in = pages_in_use_ff;
      res_in          = res_ff;
      rsp_in          = rsp_ff;
      meta_we         = 1'b0;
      meta_wdata      = {cur_cnt, cur_alive};
      rec_we          = 1'b0;
      rec_wslot       = '0;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               // Latch the beat; insert walks from page 0.
               item_in     = req_data;
               page_oob_in = (CMP_W'(req_data.page_index) >= CMP_W'(pages_in_use_ff));
               if (req_data.action == sprs_pkg::ACT_INSERT) begin
                  page_ptr_in = '0;
               end else begin
                  page_ptr_in = PCNT_W'(req_data.page_index);
               end
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            // Metadata row of page_ptr is read into meta_q, ready in S_EVAL.
            state_in = S_EVAL;
         end
         S_EVAL: begin
            res_in   = '0;
            state_in = S_FINISH;
            if (item_ff.action == sprs_pkg::ACT_INSERT) begin
               if (page_ptr_ff >= pages_in_use_ff) begin
                  // Walk exhausted: open a new page or report no space.
                  if (pages_in_use_ff < PCNT_W'(MAX_PAGES)) begin
                     meta_we            = 1'b1;
                     meta_wdata         = {CNT_W'(1), ONE_BIT};
                     rec_we             = 1'b1;
                     rec_wslot          = '0;
                     pages_in_use_in    = pages_in_use_ff + PCNT_W'(1);
                     res_in.result_page = sprs_pkg::PAGE_IDX_W'(page_ptr_ff);
                  end else begin
                     res_in.status = sprs_pkg::ST_NO_SPACE;
                  end
               end else if (srch.found) begin
                  // Reuse the lowest dead slot.
                  meta_we            = 1'b1;
                  meta_wdata         = {cur_cnt, cur_alive | (ONE_BIT << srch.idx)};
                  rec_we             = 1'b1;
                  rec_wslot          = SLOT_W'(srch.idx);
                  res_in.result_page = sprs_pkg::PAGE_IDX_W'(page_ptr_ff);
                  res_in.result_slot = srch.idx;
               end else if (srch.can_append) begin
                  // Append a slot at the count.
                  meta_we            = 1'b1;
                  meta_wdata         = {cur_cnt + CNT_W'(1), cur_alive | (ONE_BIT << cur_cnt)};
                  rec_we             = 1'b1;
                  rec_wslot          = SLOT_W'(cur_cnt);
                  res_in.result_page = sprs_pkg::PAGE_IDX_W'(page_ptr_ff);
                  res_in.result_slot = sprs_pkg::SLOT_IDX_W'(cur_cnt);
               end else begin
                  // Page full: advance to the next one.
                  page_ptr_in = page_ptr_ff + PCNT_W'(1);
                  state_in    = S_LOOK;
               end
            end else if (page_oob_ff || slot_oob) begin
               res_in.status = sprs_pkg::ST_RANGE;
            end else if (!cur_alive[item_ff.slot_index[SLOT_W-1:0]]) begin
               res_in.status = sprs_pkg::ST_DELETED;
            end else begin
               case (item_ff.action)
                  sprs_pkg::ACT_DELETE: begin
                     meta_we    = 1'b1;
                     meta_wdata = {cur_cnt,
                                   cur_alive & ~(ONE_BIT << item_ff.slot_index[SLOT_W-1:0])};
                  end
                  sprs_pkg::ACT_UPDATE: begin
                     rec_we    = 1'b1;
                     rec_wslot = item_ff.slot_index[SLOT_W-1:0];
                  end
                  sprs_pkg::ACT_READ: begin
                     // Record word arrives in rec_q next cycle.
                     state_in = S_RDATA;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_RDATA: begin
            res_in.read_data = sprs_pkg::DATA_W'(rec_q_ff);
            state_in         = S_FINISH;
         end
         S_FINISH: begin
            // Hold until the rsp register is free, then hand the beat over.
            if (rsp_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         pages_in_use_ff <= PCNT_W'(1);
         slots_cfg_ff    <= sprs_pkg::SLOTS_RESET;
         rsp_valid_ff    <= 1'b0;
         page_vld_ff     <= '0;
      end else begin
         state_ff        <= state_in;
         pages_in_use_ff <= pages_in_use_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            slots_cfg_ff <= csr_data;
         end
         if (meta_we) begin
            page_vld_ff[page_addr] <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      page_oob_ff <= page_oob_in;
      page_ptr_ff <= page_ptr_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   // Metadata memory, registered read
   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[page_addr] <= meta_wdata;
      end
      meta_q_ff     <= meta_mem[page_addr];
      meta_vld_q_ff <= page_vld_ff[page_addr];
   end

   // Record memory, registered read
   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[rec_waddr] <= item_ff.record_data[RECORD_BITS-1:0];
      end
      rec_q_ff <= rec_mem[rec_raddr];
   end

   `SPRS_ASSERT_IMP(a_pages_bounded, 1'b1,
      (pages_in_use_ff >= PCNT_W'(1)) && (pages_in_use_ff <= PCNT_W'(MAX_PAGES)))
   `SPRS_ASSERT_NXT(a_accept_looks, req_valid && !req_stall, state_ff == S_LOOK)
   `SPRS_ASSERT_IMP(a_no_space_full,
      (state_ff == S_FINISH) && (res_ff.status == sprs_pkg::ST_NO_SPACE),
      pages_in_use_ff == PCNT_W'(MAX_PAGES))
   `SPRS_ASSERT_IMP(a_insert_page_open,
      (state_ff == S_FINISH) && (item_ff.action == sprs_pkg::ACT_INSERT) &&
      (res_ff.status == sprs_pkg::ST_OK),
      CMP_W'(res_ff.result_page) < CMP_W'(pages_in_use_ff))

endmodule
`default_nettype wire

// ----- test/slotted_page_record_store_tb.sv -----
// Self-checking testbench for the slotted page record store.
// Depends on sprs_pkg and the slotted_page_record_store RTL; a class-based
// scoreboard predicts every rsp beat from the req beats the block accepts.
`timescale 1ns / 1ps

// Predicts the store and checks the rsp beats in order against it.
class record_store_scoreboard;
   localparam logic [sprs_pkg::DATA_W-1:0] WORD_MASK =
      {sprs_pkg::DATA_W{1'b1}} >> (sprs_pkg::DATA_W - sprs_pkg::DEF_RECORD_BITS);

   int unsigned slot_cap;
   int unsigned open_pages;
   int unsigned slot_count [sprs_pkg::DEF_MAX_PAGES];
   logic [sprs_pkg::DEF_MAX_SLOTS-1:0] live_slots [sprs_pkg::DEF_MAX_PAGES];
   logic [sprs_pkg::DATA_W-1:0] words [sprs_pkg::DEF_MAX_PAGES][sprs_pkg::DEF_MAX_SLOTS];
   sprs_pkg::rsp_type expected_rsp_q [$];
   int errors;

   function new();
      slot_cap = sprs_pkg::SLOTS_RESET;
      open_pages = 1;
      errors = 0;
      for (int p = 0; p < sprs_pkg::DEF_MAX_PAGES; p++) begin
         slot_count[p] = 0;
         live_slots[p] = '0;
         for (int s = 0; s < sprs_pkg::DEF_MAX_SLOTS; s++) words[p][s] = '0;
      end
   endfunction

   function void set_limit(logic [sprs_pkg::CFG_W-1:0] value);
      slot_cap = value;
   endfunction

   function int pending();
      return expected_rsp_q.size();
   endfunction

   function void place(int unsigned p, int unsigned s, logic [sprs_pkg::DATA_W-1:0] word);
      live_slots[p][s] = 1'b1;
      words[p][s] = word & WORD_MASK;
   endfunction

   task report(string what, logic [sprs_pkg::DATA_W-1:0] got,
               logic [sprs_pkg::DATA_W-1:0] want);
      errors++;
      $display("mismatch %s: got %0h want %0h", what, got, want);
   endtask

   // Apply one accepted req beat to the store and queue the answer it owes.
   function void note_request(sprs_pkg::req_type r);
      sprs_pkg::rsp_type o;
      int unsigned lim;
      int unsigned p;
      int unsigned s;
      bit done;
      o = '0;
      if (r.action == sprs_pkg::ACT_INSERT) begin
         lim = slot_cap;
         if (lim < 1) lim = 1;
         if (lim > sprs_pkg::DEF_MAX_SLOTS) lim = sprs_pkg::DEF_MAX_SLOTS;
         done = 1'b0;
         for (p = 0; p < open_pages && !done; p++) begin
            // reuse the lowest dead slot first, then try to append
            for (s = 0; s < slot_count[p] && !done; s++) begin
               if (!live_slots[p][s]) begin
                  place(p, s, r.record_data);
                  o.result_page = sprs_pkg::PAGE_IDX_W'(p);
                  o.result_slot = sprs_pkg::SLOT_IDX_W'(s);
                  done = 1'b1;
               end
            end
            if (!done && slot_count[p] < lim) begin
               place(p, slot_count[p], r.record_data);
               o.result_page = sprs_pkg::PAGE_IDX_W'(p);
               o.result_slot = sprs_pkg::SLOT_IDX_W'(slot_count[p]);
               slot_count[p]++;
               done = 1'b1;
            end
         end
         if (!done) begin
            if (open_pages < sprs_pkg::DEF_MAX_PAGES) begin
               p = open_pages;
               open_pages++;
               slot_count[p] = 1;
               live_slots[p] = '0;
               place(p, 0, r.record_data);
               o.result_page = sprs_pkg::PAGE_IDX_W'(p);
            end else begin
               o.status = sprs_pkg::ST_NO_SPACE;
            end
         end
      end else begin
         p = r.page_index;
         s = r.slot_index;
         if (p >= open_pages || s >= slot_count[p]) o.status = sprs_pkg::ST_RANGE;
         else if (!live_slots[p][s]) o.status = sprs_pkg::ST_DELETED;
         else begin
            o.status = sprs_pkg::ST_OK;
            case (r.action)
               sprs_pkg::ACT_DELETE: live_slots[p][s] = 1'b0;
               sprs_pkg::ACT_UPDATE: words[p][s] = r.record_data & WORD_MASK;
               default: o.read_data = words[p][s] & WORD_MASK;
            endcase
         end
      end
      expected_rsp_q = {expected_rsp_q, o};
   endfunction

   task check_response(sprs_pkg::rsp_type got);
      sprs_pkg::rsp_type want;
      if (expected_rsp_q.size() == 0) begin
         report("unexpected rsp beat", got.read_data, '0);
      end else begin
         want = expected_rsp_q.pop_front();
         if (got.status !== want.status)
            report("status", sprs_pkg::DATA_W'(got.status), sprs_pkg::DATA_W'(want.status));
         if (got.result_page !== want.result_page)
            report("result_page", sprs_pkg::DATA_W'(got.result_page),
                   sprs_pkg::DATA_W'(want.result_page));
         if (got.result_slot !== want.result_slot)
            report("result_slot", sprs_pkg::DATA_W'(got.result_slot),
                   sprs_pkg::DATA_W'(want.result_slot));
         if (got.read_data !== want.read_data)
            report("read_data", got.read_data, want.read_data);
      end
   endtask
endclass

module slotted_page_record_store_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int IDLE_PCT = 18;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   sprs_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   sprs_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [sprs_pkg::CFG_W-1:0] csr_data = '0;

   // high during the long stretch where neither side inserts gaps
   bit calm = 1'b0;
   int cycle_count = 0;
   record_store_scoreboard sb = new();

   slotted_page_record_store dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   // Receiver back-pressure: stall at random, change only on the falling edge.
   always @(negedge clock) begin
      rsp_stall <= !reset && !calm && ($urandom_range(99) < IDLE_PCT);
   end

   // Check every rsp beat taken at a rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic sprs_pkg::req_type make_req(logic [sprs_pkg::ACTION_W-1:0] action,
                                                  int page, int slot,
                                                  logic [sprs_pkg::DATA_W-1:0] data);
      sprs_pkg::req_type r;
      r.action = action;
      r.page_index = sprs_pkg::PAGE_IDX_W'(page);
      r.slot_index = sprs_pkg::SLOT_IDX_W'(slot);
      r.record_data = data;
      return r;
   endfunction

   // Mostly aim at slots that exist (live or dead); the rest is random noise
   // that may land out of range.
   function automatic sprs_pkg::req_type random_req(int insert_pct);
      sprs_pkg::req_type r;
      int roll;
      int p;
      r.record_data = {$urandom, $urandom};
      r.page_index = sprs_pkg::PAGE_IDX_W'($urandom_range(sprs_pkg::DEF_MAX_PAGES - 1));
      r.slot_index = sprs_pkg::SLOT_IDX_W'($urandom_range(sprs_pkg::DEF_MAX_SLOTS - 1));
      roll = $urandom_range(99);
      if (roll < insert_pct) r.action = sprs_pkg::ACT_INSERT;
      else if (roll < insert_pct + (100 - insert_pct) * 2 / 5) r.action = sprs_pkg::ACT_DELETE;
      else if (roll < insert_pct + (100 - insert_pct) * 3 / 5) r.action = sprs_pkg::ACT_UPDATE;
      else r.action = sprs_pkg::ACT_READ;
      if ($urandom_range(99) < 80) begin
         p = $urandom_range(sb.open_pages - 1);
         if (sb.slot_count[p] > 0) begin
            r.page_index = sprs_pkg::PAGE_IDX_W'(p);
            r.slot_index = sprs_pkg::SLOT_IDX_W'($urandom_range(sb.slot_count[p] - 1));
         end
      end
      return r;
   endfunction

   // Drive one req beat; hold it until the block takes it.
   task automatic send_req(sprs_pkg::req_type item);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      sb.note_request(item);
   endtask

   // Drop valid and hold off until every owed rsp beat has come back.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Write the slot limit while the block is idle.
   task automatic write_limit(logic [sprs_pkg::CFG_W-1:0] value);
      drain_results();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_limit(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int limits [7] = '{64, 2, 1, 0, 127, 0, 3};
      int ins_pcts [7] = '{40, 55, 70, 60, 45, 40, 35};
      int counts [7] = '{100, 80, 80, 80, 120, 120, 120};

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, slot limit still at its reset value.
      send_req(make_req(sprs_pkg::ACT_READ, 0, 0, '0));     // empty page: out of range
      send_req(make_req(sprs_pkg::ACT_INSERT, 9, 33, '1));  // lands on page 0 slot 0
      send_req(make_req(sprs_pkg::ACT_INSERT, 0, 0, '0));   // appends slot 1
      send_req(make_req(sprs_pkg::ACT_READ, 0, 0, '0));
      send_req(make_req(sprs_pkg::ACT_UPDATE, 0, 1, 64'hA5A5_5A5A_0F0F_F0F0));
      send_req(make_req(sprs_pkg::ACT_READ, 0, 1, '1));
      send_req(make_req(sprs_pkg::ACT_DELETE, 0, 0, '0));
      send_req(make_req(sprs_pkg::ACT_DELETE, 0, 0, '0));   // tombstone already set
      send_req(make_req(sprs_pkg::ACT_READ, 0, 0, '0));
      send_req(make_req(sprs_pkg::ACT_UPDATE, 0, 0, '1));
      send_req(make_req(sprs_pkg::ACT_INSERT, 0, 0, 64'h0123_4567_89AB_CDEF)); // reuses slot 0
      send_req(make_req(sprs_pkg::ACT_DELETE, 15, 63, '0)); // page not open
      send_req(make_req(sprs_pkg::ACT_READ, 0, 63, '0));    // slot beyond the count
      send_req(make_req(sprs_pkg::ACT_UPDATE, 1, 0, '1));

      // Lower the limit below page 0's count: reuse yes, append no.
      write_limit(7'd1);
      send_req(make_req(sprs_pkg::ACT_INSERT, 0, 0, 64'h8000_0000_0000_0001)); // opens page 1
      send_req(make_req(sprs_pkg::ACT_DELETE, 0, 1, '0));
      send_req(make_req(sprs_pkg::ACT_INSERT, 0, 0, 64'hFFFF_0000_FFFF_0000)); // page 0 slot 1
      send_req(make_req(sprs_pkg::ACT_INSERT, 0, 0, 64'h5555_AAAA_5555_AAAA)); // opens page 2
      send_req(make_req(sprs_pkg::ACT_READ, 2, 0, '0));

      // Over-range limit acts as the full page, zero acts as one.
      write_limit(7'd127);
      send_req(make_req(sprs_pkg::ACT_INSERT, 0, 0, 64'h0000_FFFF_0000_FFFF));
      write_limit(7'd0);
      send_req(make_req(sprs_pkg::ACT_INSERT, 0, 0, 64'hDEAD_BEEF_CAFE_F00D));

      // Random phases, one slot limit each; small limits run the store full.
      for (int ph = 0; ph < 7; ph++) begin
         if (ph == 5) write_limit(sprs_pkg::CFG_W'($urandom_range(1, sprs_pkg::DEF_MAX_SLOTS)));
         else write_limit(sprs_pkg::CFG_W'(limits[ph]));
         calm = (ph == 2);
         for (int i = 0; i < counts[ph]; i++) begin
            // hold the sender once mid-phase until the block has drained
            if (ph == 4 && i == counts[ph] / 2) drain_results();
            send_req(random_req(ins_pcts[ph]));
         end
         calm = 1'b0;
      end

      drain_results();
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
